FILE: src/fla_pkg.sv
package fla_pkg;

    localparam int EXP_WIDTH      = 8;
    localparam int FRAC_WIDTH     = 23;
    localparam int MAX_INPUT_MSB  = 15;
    localparam int ACC_LSB_WEIGHT = -32;
    localparam int ACC_MSB_WEIGHT = 31;

    localparam int SUM_W = 64;
    localparam int CHUNK_W = 16;
    localparam int N_CHUNKS = SUM_W / CHUNK_W;

    typedef enum logic [1:0] {
        EXC_ZERO   = 2'd0,
        EXC_NORMAL = 2'd1,
        EXC_INF    = 2'd2,
        EXC_NAN    = 2'd3
    } exc_code_t;

    // per-item control travelling with the addend from the align register
    typedef struct packed {
        logic fresh;
        logic neg;
        logic ovf;
        logic unf;
    } item_ctl_t;

endpackage

FILE: src/fla_align.sv
module fla_align #(
    parameter int EXP_WIDTH      = fla_pkg::EXP_WIDTH,
    parameter int FRAC_WIDTH     = fla_pkg::FRAC_WIDTH,
    parameter int MAX_INPUT_MSB  = fla_pkg::MAX_INPUT_MSB,
    parameter int ACC_LSB_WEIGHT = fla_pkg::ACC_LSB_WEIGHT,
    parameter int ACC_MSB_WEIGHT = fla_pkg::ACC_MSB_WEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0]                   exception_code,
    input  logic                         sign,
    input  logic [7:0]                   exponent,
    input  logic [22:0]                  fraction,
    input  logic                         new_set,
    output logic                         out_valid,
    output logic [fla_pkg::SUM_W-1:0]    addend,
    output fla_pkg::item_ctl_t           ctl
);
    localparam int AW_RAW = ACC_MSB_WEIGHT - ACC_LSB_WEIGHT + 1;
    localparam int AW = (AW_RAW < 1) ? 1 : ((AW_RAW > 64) ? 64 : AW_RAW);
    localparam int BIAS = (1 << (EXP_WIDTH - 1)) - 1;
    localparam int MW = FRAC_WIDTH + 1 + 64;
    localparam int SHW = 10;

    logic                       valid_reg;
    logic [fla_pkg::SUM_W-1:0]  addend_reg;
    fla_pkg::item_ctl_t         ctl_reg;

    logic [EXP_WIDTH-1:0]       e;
    logic [FRAC_WIDTH-1:0]      f;
    logic signed [SHW+6:0]      keep;
    logic [MW-1:0]              mant_ext;
    logic [MW-1:0]              shifted;
    logic [63:0]                mag;
    logic [63:0]                wmask;
    logic                       big;
    logic                       tiny;
    logic                       normal;

    always_comb begin
        e = exponent[EXP_WIDTH-1:0];
        f = fraction[FRAC_WIDTH-1:0];
        keep = $signed({{(SHW+7-EXP_WIDTH){1'b0}}, e})
            - (SHW+7)'(BIAS + ACC_LSB_WEIGHT);
        big = $signed({{(SHW+7-EXP_WIDTH){1'b0}}, e}) > (SHW+7)'(MAX_INPUT_MSB + BIAS);
        tiny = keep < 0;
        normal = exception_code == fla_pkg::EXC_NORMAL;
        // mantissa sits with its lsb at bit position keep-FRAC_WIDTH of a
        // window whose low FRAC_WIDTH bits hold the truncated part
        mant_ext = {{(MW-FRAC_WIDTH-1){1'b0}}, 1'b1, f};
        if (tiny || keep > 64 + FRAC_WIDTH) begin
            shifted = '0;
        end else begin
            shifted = mant_ext << keep[SHW-1:0];
        end
        wmask = (AW >= 64) ? {64{1'b1}} : ((64'd1 << AW) - 64'd1);
        mag = shifted[FRAC_WIDTH +: 64] & wmask;
        if (!normal || big || tiny) begin
            mag = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            addend_reg    <= sign ? ((64'd0 - mag) & wmask) : mag;
            ctl_reg.fresh <= new_set;
            ctl_reg.neg   <= sign;
            ctl_reg.ovf   <= exception_code[1] || (normal && big);
            ctl_reg.unf   <= (exception_code == fla_pkg::EXC_ZERO)
                             || (normal && !big && tiny);
        end
    end

    assign out_valid = valid_reg;
    assign addend    = addend_reg;
    assign ctl       = ctl_reg;
endmodule

FILE: src/fla_cell.sv
module fla_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic                           fresh,
    input  logic [fla_pkg::CHUNK_W-1:0]    a,
    input  logic                           cin,
    output logic [fla_pkg::CHUNK_W-1:0]    s,
    output logic                           cout
);
    // one chunk of the accumulator; local chunk state plus carry to the next cell
    logic [fla_pkg::CHUNK_W-1:0] acc_reg;
    logic [fla_pkg::CHUNK_W:0]   sum;

    always_comb begin
        sum = {1'b0, (fresh ? {fla_pkg::CHUNK_W{1'b0}} : acc_reg)} + {1'b0, a}
            + {{fla_pkg::CHUNK_W{1'b0}}, cin};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= sum[fla_pkg::CHUNK_W-1:0];
        end
    end

    assign s    = sum[fla_pkg::CHUNK_W-1:0];
    assign cout = sum[fla_pkg::CHUNK_W];
endmodule

FILE: src/fp_long_accumulator.sv
// Channel   Dir  tdata (lsb up)                              tuser
// s_axis    in   exception_code, sign, exponent, fraction    new_set
// m_axis    out  sum                                         input_overflow, input_underflow,
//                                                             sum_overflow
// One transaction per cycle unless stalled; the align register loads when an item is accepted,
// and the result register loads from it when the pipeline next advances.
// Accumulator add is a row of four 16-bit cells; the carry chain is the critical path.
// Synchronous active-low reset clears sticky flags and valids; the next item starts afresh.
// The whole pipeline advances only when the output register is free or being taken.
module fp_long_accumulator #(
    parameter int EXP_WIDTH      = fla_pkg::EXP_WIDTH,
    parameter int FRAC_WIDTH     = fla_pkg::FRAC_WIDTH,
    parameter int MAX_INPUT_MSB  = fla_pkg::MAX_INPUT_MSB,
    parameter int ACC_LSB_WEIGHT = fla_pkg::ACC_LSB_WEIGHT,
    parameter int ACC_MSB_WEIGHT = fla_pkg::ACC_MSB_WEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // exception_code[1:0], sign, exponent[7:0], fraction[22:0]
    input  logic        s_axis_tuser,  // new_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // sum
    output logic [2:0]  m_axis_tuser   // input_overflow, input_underflow, sum_overflow
);
    localparam int AW_RAW = ACC_MSB_WEIGHT - ACC_LSB_WEIGHT + 1;
    localparam int AW = (AW_RAW < 1) ? 1 : ((AW_RAW > 64) ? 64 : AW_RAW);
    localparam int CW = fla_pkg::CHUNK_W;
    localparam int NC = fla_pkg::N_CHUNKS;

    logic                en;
    logic                a_valid;
    logic [63:0]         addend;
    fla_pkg::item_ctl_t  ctl;
    logic [NC:0]         carry;
    logic [63:0]         raw;
    logic [63:0]         wmask;
    logic [63:0]         res;
    logic [63:0]         old;
    logic [63:0]         sext;
    logic                top_o, top_a, top_r;

    logic                out_valid_reg;
    logic [63:0]         sum_reg;
    logic                ovf_reg, unf_reg, sovf_reg;
    logic                ovf_next, unf_next, sovf_next;
    logic [63:0]         acc_shadow_reg;
    logic                aresetn_q;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fla_align #(
        .EXP_WIDTH(EXP_WIDTH), .FRAC_WIDTH(FRAC_WIDTH), .MAX_INPUT_MSB(MAX_INPUT_MSB),
        .ACC_LSB_WEIGHT(ACC_LSB_WEIGHT), .ACC_MSB_WEIGHT(ACC_MSB_WEIGHT)
    ) u_align (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_axis_tvalid),
        .exception_code(s_axis_tdata[1:0]),
        .sign(s_axis_tdata[2]),
        .exponent(s_axis_tdata[10:3]),
        .fraction(s_axis_tdata[33:11]),
        .new_set(s_axis_tuser),
        .out_valid(a_valid), .addend(addend), .ctl(ctl)
    );

    assign carry[0] = 1'b0;
    for (genvar i = 0; i < NC; i++) begin : g_cell
        fla_cell u_cell (
            .aclk(aclk), .en(en && a_valid), .fresh(ctl.fresh || !aresetn_q),
            .a(addend[i*CW +: CW]), .cin(carry[i]),
            .s(raw[i*CW +: CW]), .cout(carry[i+1])
        );
    end

    // cells power up unknown; first item after reset behaves as fresh
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aresetn_q <= 1'b0;
        end else if (en && a_valid) begin
            aresetn_q <= 1'b1;
        end
    end

    always_comb begin
        wmask = (AW >= 64) ? {64{1'b1}} : ((64'd1 << AW) - 64'd1);
        old   = (ctl.fresh || !aresetn_q) ? 64'd0 : (acc_shadow_reg & wmask);
        res   = raw & wmask;
        top_o = old[AW-1];
        top_a = addend[AW-1];
        top_r = res[AW-1];
        sext  = res;
        if (AW < 64 && top_r) begin
            sext = res | ~wmask;
        end
        ovf_next  = ovf_reg || ctl.ovf;
        unf_next  = unf_reg || ctl.unf;
        sovf_next = sovf_reg || ((top_o == top_a) && (top_r != top_o));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            unf_reg       <= 1'b0;
            sovf_reg      <= 1'b0;
        end else if (en) begin
            out_valid_reg <= a_valid;
            if (a_valid) begin
                ovf_reg  <= ovf_next;
                unf_reg  <= unf_next;
                sovf_reg <= sovf_next;
            end
        end
        if (en && a_valid) begin
            sum_reg        <= sext;
            acc_shadow_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sum_reg;
    assign m_axis_tuser  = {sovf_reg, unf_reg, ovf_reg};

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_sticky_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tuser[0] |=> m_axis_tuser[0])
        else $error("input overflow flag dropped");
    a_sticky_sovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tuser[2] |=> m_axis_tuser[2])
        else $error("sum overflow flag dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
`endif
endmodule

FILE: bench/tb.sv
module tb;

    localparam int BIAS        = (1 << (fla_pkg::EXP_WIDTH - 1)) - 1;
    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] E_ONE     = 8'(BIAS);
    localparam logic [7:0] E_TOP     = 8'(BIAS + fla_pkg::MAX_INPUT_MSB);
    localparam logic [7:0] E_TOO_BIG = 8'(BIAS + fla_pkg::MAX_INPUT_MSB + 1);
    localparam logic [7:0] E_LSB     = 8'(BIAS + fla_pkg::ACC_LSB_WEIGHT);
    localparam logic [7:0] E_BELOW   = 8'(BIAS + fla_pkg::ACC_LSB_WEIGHT - 1);

    typedef struct packed {
        fla_pkg::exc_code_t code;
        logic               sign;
        logic [7:0]         exponent;
        logic [22:0]        fraction;
        logic               new_set;
    } fp_item_t;

    typedef struct packed {
        logic [63:0] sum;
        logic        in_ovf;
        logic        in_unf;
        logic        sum_ovf;
    } acc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    fp_item_t    pending_items[$];
    acc_result_t expected_sums[$];
    int          n_errors = 0;
    int          cycle = 0;
    int          send_idle_pct = 6;
    int          recv_idle_pct = 88;

    // model state
    logic [63:0] acc_value = '0;
    logic        ovf_seen = 1'b0;
    logic        unf_seen = 1'b0;
    logic        acc_ovf_seen = 1'b0;

    fp_long_accumulator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // exception_code, sign, exponent, fraction
        .s_axis_tuser  (s_axis_tuser),  // new_set
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // sum
        .m_axis_tuser  (m_axis_tuser)   // input_overflow, input_underflow, sum_overflow
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [39:0] pack_item(fp_item_t it);
        return {6'd0, it.fraction, it.exponent, it.sign, it.code};
    endfunction

    // aligns, accumulates and updates the sticky flags for one transaction
    function automatic void accumulate_item(fp_item_t it);
        logic [63:0] addend, mag, prev, res;
        logic [23:0] mant;
        int          keep, sh;
        addend = '0;
        if (it.code == fla_pkg::EXC_INF || it.code == fla_pkg::EXC_NAN) begin
            ovf_seen = 1'b1;
        end else if (it.code == fla_pkg::EXC_ZERO) begin
            unf_seen = 1'b1;
        end else if (int'(it.exponent) > fla_pkg::MAX_INPUT_MSB + BIAS) begin
            ovf_seen = 1'b1;
        end else begin
            keep = int'(it.exponent) - BIAS - fla_pkg::ACC_LSB_WEIGHT;
            if (keep < 0) begin
                unf_seen = 1'b1;
            end else begin
                mant = {1'b1, it.fraction};
                sh = keep - fla_pkg::FRAC_WIDTH;
                if (sh >= 64) mag = '0;
                else if (sh >= 0) mag = {40'd0, mant} << sh;
                else mag = {40'd0, mant} >> (-sh);
                addend = it.sign ? -mag : mag;
            end
        end
        prev = it.new_set ? 64'd0 : acc_value;
        res = prev + addend;
        if (prev[63] == addend[63] && res[63] != prev[63]) acc_ovf_seen = 1'b1;
        acc_value = res;
        expected_sums.insert(expected_sums.size(),
                             acc_result_t'{res, ovf_seen, unf_seen, acc_ovf_seen});
    endfunction

    function automatic void add_pending(fp_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_errors++;
    endtask

    function automatic fp_item_t random_item();
        fp_item_t it;
        int       r;
        it.code = fla_pkg::exc_code_t'(($urandom_range(0, 19) == 0) ?
                  2'($urandom_range(0, 3)) : fla_pkg::EXC_NORMAL);
        it.sign = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        // mostly exponents that land within the accumulator
        if (r < 8) it.exponent = 8'($urandom_range(BIAS + fla_pkg::ACC_LSB_WEIGHT - 2,
                                                   BIAS + fla_pkg::MAX_INPUT_MSB + 1));
        else it.exponent = 8'($urandom);
        it.fraction = 23'($urandom);
        it.new_set = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    function automatic fp_item_t mk(fla_pkg::exc_code_t c, logic s, logic [7:0] e,
                                    logic [22:0] f, logic n);
        fp_item_t it;
        it = '{c, s, e, f, n};
        return it;
    endfunction

    initial begin
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_ONE, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b1, E_ONE, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_ZERO, 1'b0, 8'd0, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_INF, 1'b1, 8'hff, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_NAN, 1'b0, 8'hff, 23'h7fffff, 1'b1));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_TOP, 23'h7fffff, 1'b1));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_TOO_BIG, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_LSB, 23'h7fffff, 1'b1));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b1, E_BELOW, 23'h7fffff, 1'b0));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, 8'd0, 23'd0, 1'b0));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b1, E_LSB, 23'd0, 1'b1));
        // accumulate the largest input four times with each sign
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_TOP, 23'h7fffff, 1'b1));
        repeat (3) add_pending(mk(fla_pkg::EXC_NORMAL, 1'b0, E_TOP, 23'h7fffff, 1'b0));
        add_pending(mk(fla_pkg::EXC_NORMAL, 1'b1, E_TOP, 23'h7fffff, 1'b1));
        repeat (3) add_pending(mk(fla_pkg::EXC_NORMAL, 1'b1, E_TOP, 23'h7fffff, 1'b0));
        for (int i = 0; i < N_RANDOM; i++) add_pending(random_item());
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() <= 2 * N_RANDOM / 3);
        send_idle_pct = 88;
        recv_idle_pct = 6;
        wait (pending_items.size() <= N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_sums.size() == 0);
        repeat (10) @(posedge aclk);
        if (expected_sums.size() == 0 && n_errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tdata  <= pack_item(pending_items[0]);
                    s_axis_tuser  <= pending_items[0].new_set;
                    s_axis_tvalid <= 1'b1;
                    accumulate_item(pending_items.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        acc_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata, '0);
            end else begin
                want = expected_sums.pop_front();
                if (m_axis_tdata !== want.sum) report_mismatch("sum", m_axis_tdata, want.sum);
                if (m_axis_tuser[0] !== want.in_ovf)
                    report_mismatch("input_overflow", 64'(m_axis_tuser[0]), 64'(want.in_ovf));
                if (m_axis_tuser[1] !== want.in_unf)
                    report_mismatch("input_underflow", 64'(m_axis_tuser[1]), 64'(want.in_unf));
                if (m_axis_tuser[2] !== want.sum_ovf)
                    report_mismatch("sum_overflow", 64'(m_axis_tuser[2]), 64'(want.sum_ovf));
            end
        end
    end

endmodule
